// ----- rtl/twbs_pkg.sv -----
// types and constants shared by the tick window bar statistics unit
// no dependencies

package twbs_pkg;

    localparam int DATA_W        = 32;
    localparam int CNT_W         = 16;
    localparam int SUM_W         = 48;
    localparam int REM_W         = CNT_W + 1;
    localparam int MIN_DAY_TICKS = 3;
    localparam int DIV_CNT_W     = $clog2(SUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = 6 * DATA_W + 3 * CNT_W;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 1'b0,
        REG_WINDOW_END   = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TGE_WS,
        ST_TLT_WE,
        ST_TLE_WE,
        ST_PGE_WS,
        ST_PLE_WE,
        ST_ASK,
        ST_GAP,
        ST_GMAX,
        ST_HIGH,
        ST_LOW,
        ST_SUM,
        ST_GS,
        ST_GE,
        ST_GL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        state_t step;
        logic   in_ready;
        logic   load_out;
    } ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] res;
        logic             borrow;
        logic             zero;
    } alu_res_t;

endpackage

// ----- rtl/twbs_alu.sv -----
// shared add / subtract / compare unit
// depends on twbs_pkg

module twbs_alu (
    input  twbs_pkg::alu_req_t req,
    output twbs_pkg::alu_res_t rsp
);

    logic [twbs_pkg::SUM_W:0] wide;

    always_comb begin
        if (req.sub) begin
            wide = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            wide = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res    = wide[twbs_pkg::SUM_W-1:0];
        rsp.borrow = req.sub & wide[twbs_pkg::SUM_W];
        rsp.zero   = (wide[twbs_pkg::SUM_W-1:0] == '0);
    end

endmodule

// ----- rtl/twbs_seq.sv -----
// step sequencer: walks one tick through the shared unit, then the
// end-of-day gap checks and the bit-serial division; depends on twbs_pkg

module twbs_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_beat,
    input  logic           tick_last,
    input  logic           out_free,
    output twbs_pkg::ctl_t ctl
);

    twbs_pkg::state_t              state_reg, state_next;
    logic [twbs_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= twbs_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            twbs_pkg::ST_IDLE:   if (in_beat) state_next = twbs_pkg::ST_TGE_WS;
            twbs_pkg::ST_TGE_WS: state_next = twbs_pkg::ST_TLT_WE;
            twbs_pkg::ST_TLT_WE: state_next = twbs_pkg::ST_TLE_WE;
            twbs_pkg::ST_TLE_WE: state_next = twbs_pkg::ST_PGE_WS;
            twbs_pkg::ST_PGE_WS: state_next = twbs_pkg::ST_PLE_WE;
            twbs_pkg::ST_PLE_WE: state_next = twbs_pkg::ST_ASK;
            twbs_pkg::ST_ASK:    state_next = twbs_pkg::ST_GAP;
            twbs_pkg::ST_GAP:    state_next = twbs_pkg::ST_GMAX;
            twbs_pkg::ST_GMAX:   state_next = twbs_pkg::ST_HIGH;
            twbs_pkg::ST_HIGH:   state_next = twbs_pkg::ST_LOW;
            twbs_pkg::ST_LOW:    state_next = twbs_pkg::ST_SUM;
            twbs_pkg::ST_SUM: begin
                state_next = tick_last ? twbs_pkg::ST_GS : twbs_pkg::ST_IDLE;
            end
            twbs_pkg::ST_GS:     state_next = twbs_pkg::ST_GE;
            twbs_pkg::ST_GE:     state_next = twbs_pkg::ST_GL;
            twbs_pkg::ST_GL: begin
                state_next   = twbs_pkg::ST_DIV;
                div_cnt_next = '0;
            end
            twbs_pkg::ST_DIV: begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == twbs_pkg::DIV_LAST) state_next = twbs_pkg::ST_FIN;
            end
            twbs_pkg::ST_FIN:    if (out_free) state_next = twbs_pkg::ST_IDLE;
            default:             state_next = twbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.step     = state_reg;
        ctl.in_ready = (state_reg == twbs_pkg::ST_IDLE);
        ctl.load_out = (state_reg == twbs_pkg::ST_FIN) && out_free;
    end

endmodule

// ----- rtl/tick_window_bar_statistics_unit.sv -----
// tick window bar statistics unit: high, low, average, open, close, gap and
// pair counts over one day of ticks; depends on twbs_pkg, twbs_alu, twbs_seq
// a new tick is taken only from idle, after the 11 steps of the last tick on the shared unit;
// a day-closing tick also goes through 3 gap steps and 48 division steps
// before its result beat is shown, plus any wait for the result slot
// reset: synchronous active-low aresetn clears window registers and day state

module tick_window_bar_statistics_unit #(
    parameter int MAX_DAY_TICKS = 65535
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tick_time, tick_value, tick_ask
    input  logic [twbs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bar_high, bar_low, bar_average, window_count, bar_open, bar_close,
    // max_gap, pair_count, change_count
    output logic [twbs_pkg::M_TDATA_W-1:0]    m_tdata,
    // bar_valid, open_valid
    output logic [twbs_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [twbs_pkg::DATA_W-1:0]       cfg_data
);

    localparam int TW = $clog2(MAX_DAY_TICKS + 1);
    localparam int DW = twbs_pkg::DATA_W;
    localparam int CW = twbs_pkg::CNT_W;
    localparam int SW = twbs_pkg::SUM_W;
    localparam int RW = twbs_pkg::REM_W;

    twbs_pkg::ctl_t     ctl;
    twbs_pkg::alu_req_t alu_req;
    twbs_pkg::alu_res_t alu_rsp;

    logic in_beat, out_free;

    // window registers
    logic [DW-1:0] win_start_reg, win_end_reg;

    // current tick
    logic [DW-1:0] t_reg, v_reg, a_reg;
    logic          last_reg;

    // per-tick flags
    logic          t_ge_ws_reg, t_lt_we_reg, t_le_we_reg, p_ok_reg, ask_ne_reg;
    logic [DW-1:0] gap_reg, end_gap_reg, mg_reg;
    logic [RW-1:0] rem_reg;

    // day state
    logic [TW-1:0] ticks_seen_reg;
    logic [DW-1:0] prev_time_reg, prev_ask_reg, first_time_reg;
    logic [DW-1:0] high_reg, low_reg;
    logic [SW-1:0] sum_reg;
    logic [CW-1:0] inside_cnt_reg;
    logic [DW-1:0] before_val_reg, close_val_reg, largest_gap_reg;
    logic          before_seen_reg, before_first_reg, close_seen_reg;
    logic [CW-1:0] pairs_reg, changes_reg;

    // result slot
    logic [twbs_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [twbs_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic                           m_tvalid_reg;

    logic          in_win, pair_hit, day_first, bar_ok, win_ok, open_ok;
    logic [RW-1:0] rem_sh;
    logic [DW-1:0] o_high, o_low, o_avg, o_open, o_close;
    logic [CW-1:0] o_cnt;

    assign in_beat   = s_tvalid & ctl.in_ready;
    assign s_tready  = ctl.in_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tvalid  = m_tvalid_reg;

    assign in_win    = t_ge_ws_reg & t_lt_we_reg;
    assign day_first = (ticks_seen_reg == '0);
    assign pair_hit  = !day_first & p_ok_reg & t_ge_ws_reg & t_le_we_reg;
    assign rem_sh    = {rem_reg[RW-2:0], sum_reg[SW-1]};

    twbs_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_beat),
        .tick_last (last_reg),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    twbs_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // operand selection for the shared unit
    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        case (ctl.step)
            twbs_pkg::ST_TGE_WS: begin
                alu_req.a = SW'(t_reg);
                alu_req.b = SW'(win_start_reg);
            end
            twbs_pkg::ST_TLT_WE: begin
                alu_req.a = SW'(t_reg);
                alu_req.b = SW'(win_end_reg);
            end
            twbs_pkg::ST_TLE_WE: begin
                alu_req.a = SW'(win_end_reg);
                alu_req.b = SW'(t_reg);
            end
            twbs_pkg::ST_PGE_WS: begin
                alu_req.a = SW'(prev_time_reg);
                alu_req.b = SW'(win_start_reg);
            end
            twbs_pkg::ST_PLE_WE: begin
                alu_req.a = SW'(win_end_reg);
                alu_req.b = SW'(prev_time_reg);
            end
            twbs_pkg::ST_ASK: begin
                alu_req.a = SW'(a_reg);
                alu_req.b = SW'(prev_ask_reg);
            end
            twbs_pkg::ST_GAP: begin
                alu_req.a = SW'(t_reg);
                alu_req.b = SW'(prev_time_reg);
            end
            twbs_pkg::ST_GMAX: begin
                alu_req.a = SW'(largest_gap_reg);
                alu_req.b = SW'(gap_reg);
            end
            twbs_pkg::ST_HIGH: begin
                alu_req.a = SW'(high_reg);
                alu_req.b = SW'(v_reg);
            end
            twbs_pkg::ST_LOW: begin
                alu_req.a = SW'(v_reg);
                alu_req.b = SW'(low_reg);
            end
            twbs_pkg::ST_SUM: begin
                alu_req.a   = sum_reg;
                alu_req.b   = SW'(v_reg);
                alu_req.sub = 1'b0;
            end
            twbs_pkg::ST_GS: begin
                alu_req.a = SW'(first_time_reg);
                alu_req.b = SW'(win_start_reg);
            end
            twbs_pkg::ST_GE: begin
                alu_req.a = SW'(mg_reg);
                alu_req.b = SW'(end_gap_reg);
            end
            twbs_pkg::ST_GL: begin
                alu_req.a = SW'(mg_reg);
                alu_req.b = SW'(largest_gap_reg);
            end
            twbs_pkg::ST_DIV: begin
                alu_req.a = SW'(rem_sh);
                alu_req.b = SW'(inside_cnt_reg);
            end
            default: begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    // result fields
    always_comb begin
        bar_ok  = before_seen_reg && (ticks_seen_reg >= TW'(twbs_pkg::MIN_DAY_TICKS));
        win_ok  = bar_ok && (inside_cnt_reg != '0);
        open_ok = bar_ok && !before_first_reg;
        o_high  = win_ok ? high_reg : '0;
        o_low   = win_ok ? low_reg : '0;
        o_avg   = win_ok ? sum_reg[DW-1:0] : '0;
        o_cnt   = win_ok ? inside_cnt_reg : '0;
        o_open  = open_ok ? before_val_reg : '0;
        o_close = bar_ok ? (close_seen_reg ? close_val_reg : v_reg) : '0;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= '0;
            win_end_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (twbs_pkg::cfg_reg_t'(cfg_index))
                twbs_pkg::REG_WINDOW_START: win_start_reg <= cfg_data;
                twbs_pkg::REG_WINDOW_END:   win_end_reg   <= cfg_data;
            endcase
        end
    end

    // tick capture and per-tick scratch
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            t_reg    <= s_tdata[DW-1:0];
            v_reg    <= s_tdata[2*DW-1:DW];
            a_reg    <= s_tdata[3*DW-1:2*DW];
            last_reg <= s_tlast;
        end
        case (ctl.step)
            twbs_pkg::ST_TGE_WS: t_ge_ws_reg <= !alu_rsp.borrow;
            twbs_pkg::ST_TLT_WE: t_lt_we_reg <= alu_rsp.borrow;
            twbs_pkg::ST_TLE_WE: begin
                t_le_we_reg <= !alu_rsp.borrow;
                end_gap_reg <= alu_rsp.borrow ? '0 : alu_rsp.res[DW-1:0];
            end
            twbs_pkg::ST_PGE_WS: p_ok_reg   <= !alu_rsp.borrow;
            twbs_pkg::ST_PLE_WE: p_ok_reg   <= p_ok_reg & !alu_rsp.borrow;
            twbs_pkg::ST_ASK:    ask_ne_reg <= !alu_rsp.zero;
            twbs_pkg::ST_GAP:    gap_reg <= alu_rsp.borrow ? '0 : alu_rsp.res[DW-1:0];
            twbs_pkg::ST_GS:     mg_reg  <= alu_rsp.borrow ? '0 : alu_rsp.res[DW-1:0];
            twbs_pkg::ST_GE:     if (alu_rsp.borrow) mg_reg <= end_gap_reg;
            twbs_pkg::ST_GL: begin
                if (alu_rsp.borrow) mg_reg <= largest_gap_reg;
                rem_reg <= '0;
            end
            twbs_pkg::ST_DIV: rem_reg <= alu_rsp.borrow ? rem_sh : alu_rsp.res[RW-1:0];
            default: begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // day state
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.load_out) begin
            ticks_seen_reg   <= '0;
            prev_time_reg    <= '0;
            prev_ask_reg     <= '0;
            first_time_reg   <= '0;
            high_reg         <= '0;
            low_reg          <= '0;
            sum_reg          <= '0;
            inside_cnt_reg   <= '0;
            before_val_reg   <= '0;
            before_seen_reg  <= 1'b0;
            before_first_reg <= 1'b0;
            close_val_reg    <= '0;
            close_seen_reg   <= 1'b0;
            largest_gap_reg  <= '0;
            pairs_reg        <= '0;
            changes_reg      <= '0;
        end else begin
            case (ctl.step)
                twbs_pkg::ST_GMAX: begin
                    if (pair_hit) begin
                        if (alu_rsp.borrow) largest_gap_reg <= gap_reg;
                        if (pairs_reg != '1) pairs_reg <= pairs_reg + 1'b1;
                        if (ask_ne_reg && changes_reg != '1) changes_reg <= changes_reg + 1'b1;
                    end
                end
                twbs_pkg::ST_HIGH: begin
                    if (in_win && (inside_cnt_reg == '0 || alu_rsp.borrow)) high_reg <= v_reg;
                end
                twbs_pkg::ST_LOW: begin
                    if (in_win && (inside_cnt_reg == '0 || alu_rsp.borrow)) low_reg <= v_reg;
                end
                twbs_pkg::ST_SUM: begin
                    if (in_win && inside_cnt_reg != '1) begin
                        sum_reg        <= alu_rsp.res;
                        inside_cnt_reg <= inside_cnt_reg + 1'b1;
                    end
                    if (day_first) first_time_reg <= t_reg;
                    if (!t_ge_ws_reg) begin
                        before_val_reg   <= v_reg;
                        before_seen_reg  <= 1'b1;
                        before_first_reg <= day_first;
                    end
                    if (t_lt_we_reg) begin
                        close_val_reg  <= v_reg;
                        close_seen_reg <= 1'b1;
                    end
                    if (ticks_seen_reg != TW'(MAX_DAY_TICKS)) begin
                        ticks_seen_reg <= ticks_seen_reg + 1'b1;
                    end
                    prev_time_reg <= t_reg;
                    prev_ask_reg  <= a_reg;
                end
                twbs_pkg::ST_DIV: begin
                    // quotient bits shift in as the dividend shifts out
                    sum_reg <= {sum_reg[SW-2:0], !alu_rsp.borrow};
                end
                default: begin
                    sum_reg <= sum_reg;
                end
            endcase
        end
    end

    // result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_tdata_reg <= {changes_reg, pairs_reg, mg_reg, o_close, o_open,
                            o_cnt, o_avg, o_low, o_high};
            m_tuser_reg <= {open_ok, bar_ok};
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for tick_window_bar_statistics_unit: directed days, then
// random days under four flow-control phases
// depends on twbs_pkg and the rtl of the unit

module tb_top;

    localparam int          DAY_TICK_LIMIT = 65535;
    localparam int          SETTLE_CYCLES  = 80;
    localparam int          DRAIN_CYCLES   = 100;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PHASE_TICKS    = 420;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct {
        logic        bar_valid;
        logic        open_valid;
        logic [31:0] bar_high;
        logic [31:0] bar_low;
        logic [31:0] bar_average;
        logic [15:0] window_count;
        logic [31:0] bar_open;
        logic [31:0] bar_close;
        logic [31:0] max_gap;
        logic [15:0] pair_count;
        logic [15:0] change_count;
    } bar_t;

    class bar_scoreboard;
        logic [31:0] win_start;
        logic [31:0] win_end;
        int          day_ticks;
        logic [31:0] prev_time;
        logic [31:0] prev_ask;
        logic [31:0] first_time;
        logic [31:0] run_high;
        logic [31:0] run_low;
        logic [47:0] run_sum;
        logic [15:0] win_ticks;
        logic [31:0] open_value;
        logic        open_seen;
        logic        open_is_first;
        logic [31:0] close_value;
        logic        close_seen;
        logic [31:0] widest_gap;
        logic [15:0] pair_total;
        logic [15:0] ask_change_total;
        bar_t        expected_bars[$];
        int          mismatches;

        function new();
            win_start  = '0;
            win_end    = '0;
            mismatches = 0;
            clear_day();
        endfunction

        function void clear_day();
            day_ticks        = 0;
            prev_time        = '0;
            prev_ask         = '0;
            first_time       = '0;
            run_high         = '0;
            run_low          = '0;
            run_sum          = '0;
            win_ticks        = '0;
            open_value       = '0;
            open_seen        = 1'b0;
            open_is_first    = 1'b0;
            close_value      = '0;
            close_seen       = 1'b0;
            widest_gap       = '0;
            pair_total       = '0;
            ask_change_total = '0;
        endfunction

        function void set_reg(twbs_pkg::cfg_reg_t idx, logic [31:0] value);
            if (idx == twbs_pkg::REG_WINDOW_START) begin
                win_start = value;
            end else begin
                win_end = value;
            end
        endfunction

        function logic in_closed(logic [31:0] t);
            return t >= win_start && t <= win_end;
        endfunction

        function void note_tick(logic [31:0] t, logic [31:0] v, logic [31:0] a, logic last);
            bar_t        r;
            logic [31:0] gap;
            logic [31:0] gs;
            logic [31:0] ge;
            logic [47:0] quotient;
            if (day_ticks == 0) begin
                first_time = t;
            end else if (in_closed(prev_time) && in_closed(t)) begin
                gap = (t >= prev_time) ? t - prev_time : 32'd0;
                if (gap > widest_gap) widest_gap = gap;
                if (pair_total != COUNT_MAX) pair_total++;
                if (a != prev_ask && ask_change_total != COUNT_MAX) ask_change_total++;
            end
            if (t >= win_start && t < win_end) begin
                if (win_ticks == 0) begin
                    run_high = v;
                    run_low  = v;
                end else begin
                    if (v > run_high) run_high = v;
                    if (v < run_low) run_low = v;
                end
                if (win_ticks != COUNT_MAX) begin
                    run_sum += v;
                    win_ticks++;
                end
            end
            if (t < win_start) begin
                open_value    = v;
                open_seen     = 1'b1;
                open_is_first = (day_ticks == 0);
            end
            if (t < win_end) begin
                close_value = v;
                close_seen  = 1'b1;
            end
            if (day_ticks < DAY_TICK_LIMIT) day_ticks++;
            prev_time = t;
            prev_ask  = a;
            if (!last) return;

            r = '{default: '0};
            r.bar_valid = open_seen && day_ticks >= twbs_pkg::MIN_DAY_TICKS;
            gs = (first_time > win_start) ? first_time - win_start : 32'd0;
            ge = (win_end > t) ? win_end - t : 32'd0;
            r.max_gap = (gs > ge) ? gs : ge;
            if (widest_gap > r.max_gap) r.max_gap = widest_gap;
            if (r.bar_valid) begin
                if (win_ticks != 0) begin
                    quotient       = run_sum / {32'd0, win_ticks};
                    r.bar_high     = run_high;
                    r.bar_low      = run_low;
                    r.bar_average  = quotient[31:0];
                    r.window_count = win_ticks;
                end
                if (!open_is_first) begin
                    r.bar_open   = open_value;
                    r.open_valid = 1'b1;
                end
                r.bar_close = close_seen ? close_value : v;
            end
            r.pair_count   = pair_total;
            r.change_count = ask_change_total;
            expected_bars = {expected_bars, r};
            clear_day();
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) flag(what, want, got);
        endfunction

        function void check_bar(logic [twbs_pkg::M_TDATA_W-1:0] data,
                                logic [twbs_pkg::M_TUSER_W-1:0] user);
            bar_t want;
            if (expected_bars.size() == 0) begin
                flag("unexpected result beat", '0, '0);
                return;
            end
            want = expected_bars.pop_front();
            compare("bar_valid",    want.bar_valid,    user[0]);
            compare("open_valid",   want.open_valid,   user[1]);
            compare("bar_high",     want.bar_high,     data[31:0]);
            compare("bar_low",      want.bar_low,      data[63:32]);
            compare("bar_average",  want.bar_average,  data[95:64]);
            compare("window_count", want.window_count, data[111:96]);
            compare("bar_open",     want.bar_open,     data[143:112]);
            compare("bar_close",    want.bar_close,    data[175:144]);
            compare("max_gap",      want.max_gap,      data[207:176]);
            compare("pair_count",   want.pair_count,   data[223:208]);
            compare("change_count", want.change_count, data[239:224]);
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic [twbs_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tlast;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [twbs_pkg::M_TDATA_W-1:0] m_tdata;
    logic [twbs_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [twbs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [twbs_pkg::DATA_W-1:0]    cfg_data;

    bar_scoreboard board;
    int            send_idle_pct;
    int            stall_pct;
    int            sent_ticks;
    int            idle_cycles;

    tick_window_bar_statistics_unit #(
        .MAX_DAY_TICKS(DAY_TICK_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_bar(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_tick(input logic [31:0] t, input logic [31:0] v,
                             input logic [31:0] a, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, v, t};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_tick(t, v, a, last);
        sent_ticks++;
    endtask

    task automatic write_window(input logic [31:0] start_s, input logic [31:0] end_s);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.expected_bars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= twbs_pkg::REG_WINDOW_START;
        cfg_data  <= start_s;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(twbs_pkg::REG_WINDOW_START, start_s);
        cfg_index <= twbs_pkg::REG_WINDOW_END;
        cfg_data  <= end_s;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(twbs_pkg::REG_WINDOW_END, end_s);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_window();
        logic [31:0] start_s;
        case ($urandom_range(9))
            0: write_window(32'd0, 32'd0);
            1: write_window(32'd0, 32'hFFFF_FFFF);
            2: write_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: begin
                start_s = $urandom;
                write_window(start_s, start_s - $urandom_range(1, 100));
            end
            4: begin
                start_s = $urandom_range(0, 40);
                write_window(start_s, start_s + $urandom_range(1, 300));
            end
            default: begin
                start_s = $urandom;
                write_window(start_s, start_s + $urandom_range(1, 300));
            end
        endcase
    endtask

    task automatic run_day(input int n);
        logic [31:0] t;
        logic [31:0] v;
        logic [31:0] a;
        int          pick;
        t = (board.win_start > 60) ? board.win_start - $urandom_range(60)
                                   : 32'($urandom_range(20));
        a = $urandom;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                t = $urandom;
            end else if (pick < 10) begin
                t = t - $urandom_range(20);
            end else begin
                t = t + $urandom_range(40);
            end
            case ($urandom_range(9))
                0: v = 32'd0;
                1: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            if ($urandom_range(1)) a = $urandom;
            send_tick(t, v, a, i == n - 1);
        end
    endtask

    initial begin
        int idle_plan[4];
        int stall_plan[4];
        int phase_start;
        int n;
        idle_plan  = '{0, 77, 0, 35};
        stall_plan = '{0, 0, 77, 35};
        board         = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        sent_ticks    = 0;
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tvalid  <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= twbs_pkg::REG_WINDOW_START;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window is empty at zero: no tick can precede start
        send_tick(32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0);
        send_tick(32'd5, 32'd3, 32'd1, 1'b0);
        send_tick(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);

        write_window(32'd100, 32'd200);
        // full bar with open, window extremes and closed-window pairs
        send_tick(32'd50, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_tick(32'd60, 32'd1, 32'd0, 1'b0);
        send_tick(32'd100, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_tick(32'd150, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_tick(32'd199, 32'd12345, 32'd5, 1'b0);
        send_tick(32'd200, 32'd777, 32'd6, 1'b0);
        send_tick(32'd250, 32'd888, 32'd6, 1'b1);
        // single tick and two-tick days: bar invalid
        send_tick(32'd10, 32'd42, 32'd1, 1'b1);
        send_tick(32'd50, 32'd42, 32'd1, 1'b0);
        send_tick(32'd150, 32'd43, 32'd2, 1'b1);
        // open is the first tick
        send_tick(32'd50, 32'd9, 32'd1, 1'b0);
        send_tick(32'd150, 32'd10, 32'd2, 1'b0);
        send_tick(32'd160, 32'd11, 32'd3, 1'b1);
        // time going backwards
        send_tick(32'd50, 32'd20, 32'd1, 1'b0);
        send_tick(32'd180, 32'd21, 32'd2, 1'b0);
        send_tick(32'd120, 32'd22, 32'd3, 1'b0);
        send_tick(32'd300, 32'd23, 32'd3, 1'b1);
        // empty window
        send_tick(32'd10, 32'd30, 32'd1, 1'b0);
        send_tick(32'd20, 32'd31, 32'd1, 1'b0);
        send_tick(32'd300, 32'd32, 32'd1, 1'b1);
        // window moved in the middle of a day
        send_tick(32'd50, 32'd40, 32'd1, 1'b0);
        send_tick(32'd60, 32'd41, 32'd2, 1'b0);
        write_window(32'd0, 32'hFFFF_FFFF);
        send_tick(32'd70, 32'd42, 32'd3, 1'b0);
        send_tick(32'd80, 32'd43, 32'd4, 1'b1);
        // end before start, no tick before end
        write_window(32'd200, 32'd100);
        send_tick(32'd150, 32'd50, 32'd1, 1'b0);
        send_tick(32'd160, 32'd51, 32'd1, 1'b0);
        send_tick(32'd170, 32'd52, 32'd2, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph];
            stall_pct     = stall_plan[ph];
            phase_start   = sent_ticks;
            while (sent_ticks - phase_start < PHASE_TICKS) begin
                pick_window();
                repeat ($urandom_range(4, 12)) begin
                    case ($urandom_range(19))
                        0, 1: n = $urandom_range(1, 2);
                        2: n = $urandom_range(20, 40);
                        default: n = $urandom_range(3, 12);
                    endcase
                    run_day(n);
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.expected_bars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_bars.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- tick_window_bar_statistics_unit.f -----
rtl/twbs_pkg.sv
rtl/twbs_alu.sv
rtl/twbs_seq.sv
rtl/tick_window_bar_statistics_unit.sv
tb/tb_top.sv
